FILE: hdl/toric_syndrome_extractor_macros.svh
// Assertion macros used by the toric syndrome extractor back end.
`ifndef TORIC_SYNDROME_EXTRACTOR_MACROS_SVH
`define TORIC_SYNDROME_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked on aclk outside reset.
`define TSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define TSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tse_pkg.sv
// Types and constants shared by the toric syndrome extractor modules.
package tse_pkg;

    localparam int COORD_W = 3;

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_FLIP    = 2'd1;
    localparam logic [1:0] ACT_MEASURE = 2'd2;

    localparam logic [1:0] EDGE_SEL_1 = 2'd1;
    localparam logic [1:0] EDGE_SEL_2 = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [COORD_W-1:0] site_x;
        logic [COORD_W-1:0] site_y;
        logic [1:0]         edge_select;
    } in_item_t;

    typedef struct packed {
        logic               anyon_found;
        logic [COORD_W-1:0] anyon_x;
        logic [COORD_W-1:0] anyon_y;
        logic               logical_first;
        logic               logical_second;
        logic               last;
    } result_t;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_FLIP,
        CMD_MEASURE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               edge2;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLIP,
        ST_PAR,
        ST_SCAN,
        ST_FIN
    } back_state_t;

endpackage

FILE: hdl/tse_ram.sv
// Generic RAM with one write port and two registered read ports.
module tse_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr_a,
    output logic [WIDTH-1:0] rd_data_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a_reg <= mem_reg[rd_addr_a];
            rd_data_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

FILE: hdl/tse_front.sv
// Front end: accepts input transfers and turns them into queued commands.
module tse_front
    import tse_pkg::*;
#(
    parameter int LATTICE_SIZE = 8
) (
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_full,
    output logic     q_push,
    output cmd_t     q_data
);

    logic accept;
    logic keep;
    logic coord_ok;
    logic sel_ok;

    // Coordinates are compared one bit wider so that a size of eight fits.
    assign coord_ok = ({1'b0, s_data.site_x} < (COORD_W + 1)'(LATTICE_SIZE))
                   && ({1'b0, s_data.site_y} < (COORD_W + 1)'(LATTICE_SIZE));
    assign sel_ok   = (s_data.edge_select == EDGE_SEL_1)
                   || (s_data.edge_select == EDGE_SEL_2);

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    always_comb begin
        keep        = 1'b0;
        q_data.op   = CMD_CLEAR;
        q_data.x    = s_data.site_x;
        q_data.y    = s_data.site_y;
        q_data.edge2 = (s_data.edge_select == EDGE_SEL_2);
        unique case (s_data.action)
            ACT_CLEAR: begin
                keep      = 1'b1;
                q_data.op = CMD_CLEAR;
            end
            ACT_FLIP: begin
                // Out-of-range flips are absorbed here and never reach the back end.
                keep      = coord_ok && sel_ok;
                q_data.op = CMD_FLIP;
            end
            ACT_MEASURE: begin
                keep      = 1'b1;
                q_data.op = CMD_MEASURE;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = accept && keep;

endmodule

FILE: hdl/tse_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
module tse_cmd_fifo
    import tse_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/tse_back.sv
// Back end: lattice storage, flip and clear execution, and the syndrome scan.
`include "toric_syndrome_extractor_macros.svh"

module tse_back
    import tse_pkg::*;
#(
    parameter int LATTICE_SIZE = 8
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    localparam int unsigned DEPTH = LATTICE_SIZE * LATTICE_SIZE;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned SW    = 2 * COORD_W;
    localparam logic [COORD_W-1:0] LAST_C = COORD_W'(LATTICE_SIZE - 1);

    function automatic logic [AW-1:0] site_idx(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y);
        logic [SW-1:0] s;
        s = SW'(x) * SW'(LATTICE_SIZE) + SW'(y);
        return s[AW-1:0];
    endfunction

    back_state_t        state_reg, state_next;
    logic [COORD_W-1:0] x_cnt_reg, x_cnt_next;
    logic [COORD_W-1:0] y_cnt_reg, y_cnt_next;
    logic [AW-1:0]      flip_addr_reg, flip_addr_next;
    logic               flip_e2_reg, flip_e2_next;
    logic [DEPTH-1:0]   valid_reg, valid_next;
    logic               par_pend_reg, par_pend_next;
    logic               lf_reg, lf_next;
    logic               ls_reg, ls_next;
    logic               s1_vld_reg, s1_vld_next;
    logic [COORD_W-1:0] s1_x_reg, s1_x_next;
    logic [COORD_W-1:0] s1_y_reg, s1_y_next;
    logic               pend_vld_reg, pend_vld_next;
    logic [COORD_W-1:0] pend_x_reg, pend_x_next;
    logic [COORD_W-1:0] pend_y_reg, pend_y_next;
    logic               out_vld_reg, out_vld_next;
    result_t            out_reg, out_next;

    // Valid bits sampled alongside each RAM read.
    logic v_e1a_reg, v_e1b_reg, v_e2a_reg, v_e2b_reg;

    logic          rd_en;
    logic [AW-1:0] e1a, e1b, e2a, e2b;
    logic          wr_en;
    logic          wr_e1, wr_e2;
    logic          e1_rd_a, e1_rd_b, e2_rd_a, e2_rd_b;
    logic          e1a_bit, e1b_bit, e2a_bit, e2b_bit;
    logic          syn;
    logic          stall;
    logic          out_free;
    logic [COORD_W-1:0] ym, xp;

    tse_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_edge1_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (flip_addr_reg),
        .wr_data   (wr_e1),
        .rd_en     (rd_en),
        .rd_addr_a (e1a),
        .rd_data_a (e1_rd_a),
        .rd_addr_b (e1b),
        .rd_data_b (e1_rd_b)
    );

    tse_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_edge2_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (flip_addr_reg),
        .wr_data   (wr_e2),
        .rd_en     (rd_en),
        .rd_addr_a (e2a),
        .rd_data_a (e2_rd_a),
        .rd_addr_b (e2b),
        .rd_data_b (e2_rd_b)
    );

    // An entry never written since the last clear reads as zero.
    assign e1a_bit = e1_rd_a && v_e1a_reg;
    assign e1b_bit = e1_rd_b && v_e1b_reg;
    assign e2a_bit = e2_rd_a && v_e2a_reg;
    assign e2b_bit = e2_rd_b && v_e2b_reg;
    assign syn     = e1a_bit ^ e1b_bit ^ e2a_bit ^ e2b_bit;

    assign out_free = !out_vld_reg || m_ready;
    assign ym = (y_cnt_reg == '0) ? LAST_C : y_cnt_reg - 1'b1;
    assign xp = (x_cnt_reg == LAST_C) ? '0 : x_cnt_reg + 1'b1;

    always_comb begin
        state_next     = state_reg;
        x_cnt_next     = x_cnt_reg;
        y_cnt_next     = y_cnt_reg;
        flip_addr_next = flip_addr_reg;
        flip_e2_next   = flip_e2_reg;
        valid_next     = valid_reg;
        par_pend_next  = 1'b0;
        lf_next        = lf_reg;
        ls_next        = ls_reg;
        s1_vld_next    = 1'b0;
        s1_x_next      = s1_x_reg;
        s1_y_next      = s1_y_reg;
        pend_vld_next  = pend_vld_reg;
        pend_x_next    = pend_x_reg;
        pend_y_next    = pend_y_reg;
        out_vld_next   = out_vld_reg && !m_ready;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        rd_en          = 1'b0;
        e1a            = '0;
        e1b            = '0;
        e2a            = '0;
        e2b            = '0;
        wr_en          = 1'b0;
        wr_e1          = e1a_bit ^ !flip_e2_reg;
        wr_e2          = e2a_bit ^ flip_e2_reg;
        stall          = 1'b0;

        // Logical parity reads land in the cycle after they are issued.
        if (par_pend_reg) begin
            ls_next = ls_reg ^ e1a_bit;
            lf_next = lf_reg ^ e2b_bit;
        end

        // An odd stabilizer is held back until the next one shows whether it is last.
        if (s1_vld_reg && syn) begin
            if (pend_vld_reg) begin
                if (out_free) begin
                    out_vld_next            = 1'b1;
                    out_next.anyon_found    = 1'b1;
                    out_next.anyon_x        = pend_x_reg;
                    out_next.anyon_y        = pend_y_reg;
                    out_next.logical_first  = lf_reg;
                    out_next.logical_second = ls_reg;
                    out_next.last           = 1'b0;
                    pend_x_next             = s1_x_reg;
                    pend_y_next             = s1_y_reg;
                end else begin
                    stall = 1'b1;
                end
            end else begin
                pend_vld_next = 1'b1;
                pend_x_next   = s1_x_reg;
                pend_y_next   = s1_y_reg;
            end
        end
        if (stall) begin
            s1_vld_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        CMD_CLEAR: begin
                            valid_next = '0;
                        end
                        CMD_FLIP: begin
                            rd_en          = 1'b1;
                            e1a            = site_idx(cmd.x, cmd.y);
                            e2a            = e1a;
                            flip_addr_next = e1a;
                            flip_e2_next   = cmd.edge2;
                            state_next     = ST_FLIP;
                        end
                        CMD_MEASURE: begin
                            x_cnt_next = '0;
                            lf_next    = 1'b0;
                            ls_next    = 1'b0;
                            state_next = ST_PAR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FLIP: begin
                wr_en                     = 1'b1;
                valid_next[flip_addr_reg] = 1'b1;
                state_next                = ST_IDLE;
            end
            ST_PAR: begin
                rd_en         = 1'b1;
                e1a           = site_idx(x_cnt_reg, '0);
                e2b           = site_idx('0, x_cnt_reg);
                par_pend_next = 1'b1;
                if (x_cnt_reg == LAST_C) begin
                    x_cnt_next = '0;
                    y_cnt_next = '0;
                    state_next = ST_SCAN;
                end else begin
                    x_cnt_next = x_cnt_reg + 1'b1;
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    rd_en       = 1'b1;
                    e1a         = site_idx(x_cnt_reg, y_cnt_reg);
                    e2a         = e1a;
                    e1b         = site_idx(x_cnt_reg, ym);
                    e2b         = site_idx(xp, y_cnt_reg);
                    s1_vld_next = 1'b1;
                    s1_x_next   = x_cnt_reg;
                    s1_y_next   = y_cnt_reg;
                    if (y_cnt_reg == LAST_C) begin
                        y_cnt_next = '0;
                        if (x_cnt_reg == LAST_C) begin
                            state_next = ST_FIN;
                        end else begin
                            x_cnt_next = x_cnt_reg + 1'b1;
                        end
                    end else begin
                        y_cnt_next = y_cnt_reg + 1'b1;
                    end
                end
            end
            ST_FIN: begin
                if (!s1_vld_reg && out_free) begin
                    out_vld_next            = 1'b1;
                    out_next.anyon_found    = pend_vld_reg;
                    out_next.anyon_x        = pend_vld_reg ? pend_x_reg : '0;
                    out_next.anyon_y        = pend_vld_reg ? pend_y_reg : '0;
                    out_next.logical_first  = lf_reg;
                    out_next.logical_second = ls_reg;
                    out_next.last           = 1'b1;
                    pend_vld_next           = 1'b0;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            x_cnt_reg    <= '0;
            y_cnt_reg    <= '0;
            valid_reg    <= '0;
            par_pend_reg <= 1'b0;
            s1_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            x_cnt_reg    <= x_cnt_next;
            y_cnt_reg    <= y_cnt_next;
            valid_reg    <= valid_next;
            par_pend_reg <= par_pend_next;
            s1_vld_reg   <= s1_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        flip_addr_reg <= flip_addr_next;
        flip_e2_reg   <= flip_e2_next;
        lf_reg        <= lf_next;
        ls_reg        <= ls_next;
        s1_x_reg      <= s1_x_next;
        s1_y_reg      <= s1_y_next;
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        out_reg       <= out_next;
        if (rd_en) begin
            v_e1a_reg <= valid_reg[e1a];
            v_e1b_reg <= valid_reg[e1b];
            v_e2a_reg <= valid_reg[e2a];
            v_e2b_reg <= valid_reg[e2b];
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    `TSE_ASSERT_NOW(a_scan_pipe_empty,
        (state_reg == ST_IDLE) || (state_reg == ST_FLIP) || (state_reg == ST_PAR),
        !s1_vld_reg && !pend_vld_reg, "scan pipeline holds data outside a scan")
    `TSE_ASSERT_NOW(a_empty_result_is_last, out_vld_reg && !out_reg.anyon_found,
        out_reg.last, "result without an anyon is not marked last")
    `TSE_ASSERT_NEXT(a_fin_emits_last, (state_reg == ST_FIN) && (state_next == ST_IDLE),
        out_vld_reg && out_reg.last, "measure ended without a last result")
    `TSE_ASSERT_NEXT(a_stall_holds_stage, stall,
        s1_vld_reg && $stable(s1_x_reg) && $stable(s1_y_reg),
        "stalled stabilizer was lost")

endmodule

FILE: hdl/toric_syndrome_extractor.sv
// Top level of the toric syndrome extractor: front end, command queue and back end.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    in_item_t: action, site_x, site_y, edge_select
//   m_       out        m_valid/m_ready    result_t: anyon_found, anyon_x, anyon_y,
//                                          logical_first, logical_second, last
//
// In the back end a clear completes in the idle state and a flip reads the RAMs, then
// writes them. A measure starts, reads the logical parities from LATTICE_SIZE sites on
// each axis, scans every stabilizer in turn, then drains the held report and emits the
// last result; the m_ channel can stall the scan.
// Reset (aresetn low at a clock edge) zeroes the lattice and empties the queue.
// The scan stops only while a held report and a full output register are both waiting.
module toric_syndrome_extractor
    import tse_pkg::*;
#(
    parameter int LATTICE_SIZE = 8
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output result_t  m_data
);

    // Commands from the front end; invalid flips and the unused action code
    // are consumed there and never enter the queue.
    logic q_push;
    cmd_t q_data;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_head;

    tse_front #(.LATTICE_SIZE(LATTICE_SIZE)) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_data)
    );

    // The queue decouples input transfers from the multi-cycle measure.
    tse_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // The back end owns the edge RAMs and the registered result output.
    tse_back #(.LATTICE_SIZE(LATTICE_SIZE)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (!q_empty),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the toric syndrome extractor: lattice predictor, stimulus and checks.
`timescale 1ns / 1ps

module tb_top
    import tse_pkg::*;
();

    // The lattice side is fixed at the block's default size.
    localparam int LSIZE = 8;

    // Consecutive cycles without any transfer before the run is declared hung.
    // The slowest legitimate quiet stretch is a clean measure, plus a long receiver
    // stall and a long sender gap. This limit is many times that.
    localparam int IDLE_LIMIT = 4000;

    // Extra cycles after the last expected result, so that stray results still show up.
    localparam int SETTLE_CYCLES = 200;

    // Action code that the block does not use and must ignore.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Edge selector codes that select no edge, so a flip carrying them is dropped.
    localparam logic [1:0] EDGE_SEL_NONE = 2'd0;
    localparam logic [1:0] EDGE_SEL_BAD  = 2'd3;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    in_item_t s_data;
    logic     m_valid;
    logic     m_ready;
    result_t  m_data;

    // Predicted lattice. Bit 0 of each site is edge1 and bit 1 is edge2; index x * LSIZE + y.
    logic [1:0] lattice [LSIZE*LSIZE];

    // Anyon reports that the block still owes, oldest first.
    result_t pending_anyons[$];

    int  mismatch_count;
    int  idle_cycles;
    int  stall_left;

    // When set, neither side inserts gaps, which gives back-to-back stretches.
    bit  quiet_mode;

    toric_syndrome_extractor #(
        .LATTICE_SIZE(LSIZE)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 8 ns clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Length of an idle gap: mostly none or short, now and then long.
    function automatic int random_gap();
        int pick;
        if (quiet_mode) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Site index on the torus; coordinates wrap in both directions.
    function automatic int site_of(int x, int y);
        return ((x + LSIZE) % LSIZE) * LSIZE + ((y + LSIZE) % LSIZE);
    endfunction

    function automatic in_item_t make_item(logic [1:0] action, int x, int y, logic [1:0] sel);
        in_item_t item;
        item.action      = action;
        item.site_x      = COORD_W'(x);
        item.site_y      = COORD_W'(y);
        item.edge_select = sel;
        return item;
    endfunction

    // Apply one accepted item to the predicted lattice and queue the anyon reports
    // that a measure produces.
    task automatic predict_item(input in_item_t item);
        result_t found[$];
        result_t r;
        logic    row_parity;
        logic    col_parity;
        logic    odd;
        case (item.action)
            ACT_CLEAR: begin
                foreach (lattice[i]) lattice[i] = 2'b00;
            end
            ACT_FLIP: begin
                // A flip outside the lattice or with no valid edge selected changes nothing.
                if (item.site_x < LSIZE && item.site_y < LSIZE &&
                    (item.edge_select == EDGE_SEL_1 || item.edge_select == EDGE_SEL_2)) begin
                    lattice[site_of(item.site_x, item.site_y)][item.edge_select == EDGE_SEL_2]
                        ^= 1'b1;
                end
            end
            ACT_MEASURE: begin
                // Logical parities: edge2 down the x = 0 column, edge1 along the y = 0 row.
                row_parity = 1'b0;
                col_parity = 1'b0;
                for (int k = 0; k < LSIZE; k++) begin
                    row_parity ^= lattice[site_of(0, k)][1];
                    col_parity ^= lattice[site_of(k, 0)][0];
                end
                // Stabilizers are scanned with x outer and y inner.
                for (int x = 0; x < LSIZE; x++) begin
                    for (int y = 0; y < LSIZE; y++) begin
                        odd = lattice[site_of(x, y)][0] ^ lattice[site_of(x, y - 1)][0] ^
                              lattice[site_of(x, y)][1] ^ lattice[site_of(x + 1, y)][1];
                        if (odd) begin
                            r.anyon_found    = 1'b1;
                            r.anyon_x        = COORD_W'(x);
                            r.anyon_y        = COORD_W'(y);
                            r.logical_first  = row_parity;
                            r.logical_second = col_parity;
                            r.last           = 1'b0;
                            found = {found, r};
                        end
                    end
                end
                // A clean lattice still reports once, with the found flag clear.
                if (found.size() == 0) begin
                    r                = '0;
                    r.logical_first  = row_parity;
                    r.logical_second = col_parity;
                    found = {found, r};
                end
                found[found.size() - 1].last = 1'b1;
                pending_anyons = {pending_anyons, found};
            end
            default: begin
            end
        endcase
    endtask

    // Present one item and hold it until the block takes it. Valid stays high on
    // return so that a following item with no gap goes out back to back.
    task automatic send_item(input in_item_t item);
        int gap;
        gap = random_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        predict_item(item);
    endtask

    // Hold off the sender until the block has delivered everything it owes.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_anyons.size() != 0);
    endtask

    // Result side: check each transfer against the oldest pending report, then
    // decide whether to stall on the next cycle.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_anyons.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("tb: unexpected result found=%0b x=%0d y=%0d lf=%0b ls=%0b last=%0b",
                             m_data.anyon_found, m_data.anyon_x, m_data.anyon_y,
                             m_data.logical_first, m_data.logical_second, m_data.last);
            end else begin
                want = pending_anyons.pop_front();
                if (m_data.anyon_found !== want.anyon_found ||
                    m_data.anyon_x !== want.anyon_x ||
                    m_data.anyon_y !== want.anyon_y ||
                    m_data.logical_first !== want.logical_first ||
                    m_data.logical_second !== want.logical_second ||
                    m_data.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"tb: result mismatch, expected found=%0b x=%0d y=%0d lf=%0b ",
                                  "ls=%0b last=%0b, got found=%0b x=%0d y=%0d lf=%0b ls=%0b ",
                                  "last=%0b"},
                                 want.anyon_found, want.anyon_x, want.anyon_y,
                                 want.logical_first, want.logical_second, want.last,
                                 m_data.anyon_found, m_data.anyon_x, m_data.anyon_y,
                                 m_data.logical_first, m_data.logical_second, m_data.last);
                end
            end
        end
        if (stall_left == 0 && $urandom_range(0, 99) < 35) stall_left = random_gap();
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side means a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Measures on an untouched lattice, and items that must leave it untouched:
    // the unused action code and flips with no edge selected.
    task automatic test_idle_lattice();
        send_item(make_item(ACT_MEASURE, 0, 0, EDGE_SEL_NONE));
        send_item(make_item(ACT_UNUSED, 7, 7, EDGE_SEL_BAD));
        send_item(make_item(ACT_FLIP, 3, 3, EDGE_SEL_NONE));
        send_item(make_item(ACT_FLIP, 7, 7, EDGE_SEL_BAD));
        send_item(make_item(ACT_MEASURE, 7, 7, EDGE_SEL_BAD));
    endtask

    // Single defects at the lattice corners, where the neighbors wrap around,
    // a flip undone by a second flip, and a clear that erases everything.
    task automatic test_single_defects();
        send_item(make_item(ACT_FLIP, 0, 0, EDGE_SEL_1));
        send_item(make_item(ACT_MEASURE, 0, 0, EDGE_SEL_NONE));
        send_item(make_item(ACT_FLIP, 0, 0, EDGE_SEL_1));
        send_item(make_item(ACT_FLIP, 7, 7, EDGE_SEL_2));
        send_item(make_item(ACT_MEASURE, 0, 0, EDGE_SEL_NONE));
        send_item(make_item(ACT_FLIP, 7, 0, EDGE_SEL_1));
        send_item(make_item(ACT_FLIP, 0, 7, EDGE_SEL_2));
        send_item(make_item(ACT_MEASURE, 0, 0, EDGE_SEL_NONE));
        send_item(make_item(ACT_CLEAR, 7, 7, EDGE_SEL_BAD));
        send_item(make_item(ACT_MEASURE, 0, 0, EDGE_SEL_NONE));
    endtask

    // Closed loops of flips leave no anyons but toggle the logical parities.
    task automatic test_logical_loops();
        send_item(make_item(ACT_CLEAR, 0, 0, EDGE_SEL_NONE));
        for (int k = 0; k < LSIZE; k++) send_item(make_item(ACT_FLIP, k, 3, EDGE_SEL_2));
        send_item(make_item(ACT_MEASURE, 0, 0, EDGE_SEL_NONE));
        for (int k = 0; k < LSIZE; k++) send_item(make_item(ACT_FLIP, 5, k, EDGE_SEL_1));
        send_item(make_item(ACT_MEASURE, 0, 0, EDGE_SEL_NONE));
        send_item(make_item(ACT_CLEAR, 0, 0, EDGE_SEL_NONE));
    endtask

    // Setting edge1 on every even row makes every stabilizer odd, so one measure
    // yields the full 64 reports.
    task automatic test_dense_lattice();
        for (int x = 0; x < LSIZE; x++)
            for (int y = 0; y < LSIZE; y += 2)
                send_item(make_item(ACT_FLIP, x, y, EDGE_SEL_1));
        send_item(make_item(ACT_MEASURE, 0, 0, EDGE_SEL_NONE));
        send_item(make_item(ACT_CLEAR, 0, 0, EDGE_SEL_NONE));
    endtask

    // The sender stops until all reports are back, then resumes.
    task automatic test_drain_pause();
        for (int k = 0; k < 3; k++)
            send_item(make_item(ACT_FLIP, $urandom_range(0, 7), $urandom_range(0, 7),
                                $urandom_range(0, 1) ? EDGE_SEL_2 : EDGE_SEL_1));
        send_item(make_item(ACT_MEASURE, 0, 0, EDGE_SEL_NONE));
        wait_for_drain();
        send_item(make_item(ACT_MEASURE, 7, 7, EDGE_SEL_BAD));
    endtask

    // Mostly bursts of valid flips closed by a measure; some clears, and some
    // noise that the block must ignore (unused action, flips with no edge).
    task automatic test_random_traffic(input int target);
        int sent;
        int pick;
        int burst;
        sent = 0;
        while (sent < target) begin
            quiet_mode = ($urandom_range(0, 99) < 15);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                burst = $urandom_range(1, 6);
                repeat (burst)
                    send_item(make_item(ACT_FLIP, $urandom_range(0, 7), $urandom_range(0, 7),
                                        $urandom_range(0, 1) ? EDGE_SEL_2 : EDGE_SEL_1));
                send_item(make_item(ACT_MEASURE, $urandom_range(0, 7), $urandom_range(0, 7),
                                    2'($urandom_range(0, 3))));
                sent += burst + 1;
            end else if (pick < 80) begin
                send_item(make_item(ACT_CLEAR, $urandom_range(0, 7), $urandom_range(0, 7),
                                    2'($urandom_range(0, 3))));
                sent++;
            end else if (pick < 90) begin
                send_item(make_item(ACT_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                                    2'($urandom_range(0, 3))));
            end else begin
                send_item(make_item(ACT_FLIP, $urandom_range(0, 7), $urandom_range(0, 7),
                                    $urandom_range(0, 1) ? EDGE_SEL_BAD : EDGE_SEL_NONE));
            end
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        stall_left     = 0;
        quiet_mode     = 1'b0;
        foreach (lattice[i]) lattice[i] = 2'b00;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_lattice();
        test_single_defects();
        test_logical_loops();
        test_dense_lattice();
        test_drain_pause();
        test_random_traffic(80);

        // All stimulus is in; let the block finish and watch for stray results.
        s_valid <= 1'b0;
        while (pending_anyons.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
